// ===== rtl/pnfp_pkg.sv =====
// Shared widths and item types for the plane normal pipeline.
package pnfp_pkg;

   localparam int COORD_W   = 16;
   localparam int EDGE_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * EDGE_W;
   localparam int CROSS_W   = 2 * COORD_W + 4;
   localparam int MAG_W     = 2 * COORD_W + 2;
   localparam int LO_W      = 32;
   localparam int HI_W      = MAG_W - LO_W;
   localparam int SUM_W     = 72;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 4;
   localparam int FRAC_W    = 15;
   localparam int OUT_W     = FRAC_W + 1;
   localparam int DIVR_W    = ROOT_W + 1;
   localparam int SQ_STAGES = ROOT_W;
   localparam int DV_STAGES = FRAC_W + 1;
   localparam int IN_FIELDS = 9;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Cross product as magnitudes and signs, with its squared length.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [SUM_W-1:0]      sum;
   } cross_type;

   typedef struct packed {
      logic [SUM_W-1:0]      s;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
   } sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0]      len;
      logic [2:0][DIVR_W-1:0] r;
      logic [2:0][OUT_W-1:0]  q;
      logic [2:0]             neg;
   } div_type;

endpackage

// ===== rtl/plane_normal_from_points.sv =====
// Top level of the unit plane normal block.
//
// Each beat on the req_ channel carries three points of a triangle; the block
// returns one beat on the rsp_ channel with the unit normal of their plane in
// Q1.15 and a flag that marks a degenerate triangle (zero-length normal).
// A new beat is taken every cycle while the output is not stalled.
// From an accepted request beat to its response beat, the path runs through
// four front stages (edges, cross product, squares, sum), the queue,
// 36 square root stages with one root bit each, 16 division stages with
// one quotient bit each, and the output register.
// The front and back halves stall independently; the two-entry queue between
// them absorbs the difference. When a response waits on a low rsp_tready the back half holds,
// and once the queue fills the front half and req_tready drop as well.
// Reset clears every valid bit and the queue; no response is pending after it.
// Results leave in the order the requests came in.
module plane_normal_from_points (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, 16 bits each
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, normal_z, 16 bits each
   output logic [47:0]  rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser
);

   pnfp_pkg::coord_type              pt [pnfp_pkg::IN_FIELDS];
   pnfp_pkg::cross_type              fq_data;
   pnfp_pkg::cross_type              qb_data;
   logic                             fq_valid;
   logic                             fq_ready;
   logic                             qb_valid;
   logic                             qb_ready;
   logic [2:0][pnfp_pkg::OUT_W-1:0]  norm;
   logic                             degen;

   always_comb begin
      for (int k = 0; k < pnfp_pkg::IN_FIELDS; k++) begin
         pt[k] = req_tdata[k*pnfp_pkg::COORD_W +: pnfp_pkg::COORD_W];
      end
   end

   pnfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pt        (pt),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_data  (fq_data)
   );

   pnfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   pnfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_data   (qb_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_norm  (norm),
      .out_degen (degen)
   );

   assign rsp_tdata = norm;
   assign rsp_tuser = degen;

endmodule

// ===== rtl/pnfp_front.sv =====
// Front end: edges, cross product, magnitudes and squared length, four stages.
module pnfp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  pnfp_pkg::coord_type        pt [pnfp_pkg::IN_FIELDS],
   output logic                       out_valid,
   input  logic                       out_ready,
   output pnfp_pkg::cross_type        out_data
);

   logic [3:0] vld_ff;
   logic       en;

   logic signed [pnfp_pkg::EDGE_W-1:0]  ea_ff [3];
   logic signed [pnfp_pkg::EDGE_W-1:0]  eb_ff [3];
   logic signed [pnfp_pkg::CROSS_W-1:0] c_ff  [3];
   logic signed [pnfp_pkg::CROSS_W-1:0] c_in  [3];
   logic [pnfp_pkg::MAG_W-1:0]          mag_ff [3];
   logic [pnfp_pkg::MAG_W-1:0]          mag_in [3];
   logic [2:0]                          neg_ff;
   logic [2*pnfp_pkg::HI_W-1:0]         hh_ff [3];
   logic [pnfp_pkg::HI_W+pnfp_pkg::LO_W-1:0] hl_ff [3];
   logic [2*pnfp_pkg::LO_W-1:0]         ll_ff [3];
   logic [2:0][pnfp_pkg::MAG_W-1:0]     mag2_ff;
   logic [2:0]                          neg2_ff;
   logic [pnfp_pkg::SUM_W-1:0]          sum_ff;
   logic [pnfp_pkg::SUM_W-1:0]          sum_in;

   assign en        = !(vld_ff[3] && !out_ready);
   assign in_ready  = en;
   assign out_valid = vld_ff[3];
   assign out_data  = '{mag: mag2_ff, neg: neg2_ff, sum: sum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_comb begin
      logic signed [pnfp_pkg::PROD_W-1:0] p [6];
      p[0] = ea_ff[1] * eb_ff[2];
      p[1] = ea_ff[2] * eb_ff[1];
      p[2] = ea_ff[2] * eb_ff[0];
      p[3] = ea_ff[0] * eb_ff[2];
      p[4] = ea_ff[0] * eb_ff[1];
      p[5] = ea_ff[1] * eb_ff[0];
      for (int k = 0; k < 3; k++) begin
         c_in[k] = pnfp_pkg::CROSS_W'(p[2*k]) - pnfp_pkg::CROSS_W'(p[2*k+1]);
      end
   end

   always_comb begin
      logic [pnfp_pkg::CROSS_W-1:0] neg_c;
      for (int k = 0; k < 3; k++) begin
         neg_c     = -c_ff[k];
         mag_in[k] = c_ff[k][pnfp_pkg::CROSS_W-1] ? neg_c[pnfp_pkg::MAG_W-1:0]
                                                   : c_ff[k][pnfp_pkg::MAG_W-1:0];
      end
   end

   // Each square is split into 2-bit high and 32-bit low halves of the magnitude.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 3; k++) begin
         sum_in = sum_in + (pnfp_pkg::SUM_W'(hh_ff[k]) << (2 * pnfp_pkg::LO_W))
                         + (pnfp_pkg::SUM_W'(hl_ff[k]) << (pnfp_pkg::LO_W + 1))
                         + pnfp_pkg::SUM_W'(ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ea_ff[k]  <= pnfp_pkg::EDGE_W'(pt[3+k]) - pnfp_pkg::EDGE_W'(pt[k]);
            eb_ff[k]  <= pnfp_pkg::EDGE_W'(pt[6+k]) - pnfp_pkg::EDGE_W'(pt[3+k]);
            c_ff[k]   <= c_in[k];
            mag_ff[k] <= mag_in[k];
            neg_ff[k] <= c_ff[k][pnfp_pkg::CROSS_W-1];
            hh_ff[k]  <= mag_in[k][pnfp_pkg::MAG_W-1:pnfp_pkg::LO_W]
                       * mag_in[k][pnfp_pkg::MAG_W-1:pnfp_pkg::LO_W];
            hl_ff[k]  <= mag_in[k][pnfp_pkg::MAG_W-1:pnfp_pkg::LO_W]
                       * mag_in[k][pnfp_pkg::LO_W-1:0];
            ll_ff[k]  <= mag_in[k][pnfp_pkg::LO_W-1:0] * mag_in[k][pnfp_pkg::LO_W-1:0];
            mag2_ff[k] <= mag_ff[k];
         end
         neg2_ff <= neg_ff;
         sum_ff  <= sum_in;
      end
   end

endmodule

// ===== rtl/pnfp_queue.sv =====
// Two-entry queue between the front end and the back end.
module pnfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  pnfp_pkg::cross_type wr_data,
   output logic                rd_valid,
   input  logic                rd_ready,
   output pnfp_pkg::cross_type rd_data
);

   logic [1:0]          cnt_ff;
   pnfp_pkg::cross_type ent0_ff;
   pnfp_pkg::cross_type ent1_ff;
   logic                push;
   logic                pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = ent0_ff;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   // The head always sits in the first entry; a pop shifts the second one up.
   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            ent0_ff <= wr_data;
         end else begin
            ent0_ff <= ent1_ff;
            ent1_ff <= wr_data;
         end
      end else if (pop) begin
         ent0_ff <= ent1_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ent0_ff <= wr_data;
         end else begin
            ent1_ff <= wr_data;
         end
      end
   end

endmodule

// ===== rtl/pnfp_back.sv =====
// Back end: square root pipeline, division pipeline and output register.
module pnfp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  pnfp_pkg::cross_type                in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [2:0][pnfp_pkg::OUT_W-1:0]    out_norm,
   output logic                               out_degen
);

   logic                              en;
   logic [pnfp_pkg::SQ_STAGES-1:0]    sqv_ff;
   logic [pnfp_pkg::DV_STAGES-1:0]    dvv_ff;
   pnfp_pkg::sqrt_type                sq_ff [pnfp_pkg::SQ_STAGES];
   pnfp_pkg::sqrt_type                sq_in [pnfp_pkg::SQ_STAGES];
   pnfp_pkg::div_type                 dv_ff [pnfp_pkg::DV_STAGES];
   pnfp_pkg::div_type                 dv_in [pnfp_pkg::DV_STAGES];
   logic                              ov_ff;
   logic [2:0][pnfp_pkg::OUT_W-1:0]   norm_ff;
   logic [2:0][pnfp_pkg::OUT_W-1:0]   norm_in;
   logic                              degen_ff;

   assign en        = !(ov_ff && !out_ready);
   assign in_ready  = en;
   assign out_valid = ov_ff;
   assign out_norm  = norm_ff;
   assign out_degen = degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= '0;
         dvv_ff <= '0;
         ov_ff  <= 1'b0;
      end else if (en) begin
         sqv_ff <= {sqv_ff[pnfp_pkg::SQ_STAGES-2:0], in_valid};
         dvv_ff <= {dvv_ff[pnfp_pkg::DV_STAGES-2:0], sqv_ff[pnfp_pkg::SQ_STAGES-1]};
         ov_ff  <= dvv_ff[pnfp_pkg::DV_STAGES-1];
      end
   end

   // One root bit per stage: bring down two bits of the sum, try root*4+1.
   for (genvar k = 0; k < pnfp_pkg::SQ_STAGES; k++) begin : g_sq
      pnfp_pkg::sqrt_type prv;
      logic [pnfp_pkg::REM_W-1:0] rem_t;
      logic [pnfp_pkg::REM_W-1:0] trial;
      if (k == 0) begin : g_first
         assign prv = '{s: in_data.sum, rem: '0, root: '0,
                        mag: in_data.mag, neg: in_data.neg};
      end else begin : g_next
         assign prv = sq_ff[k-1];
      end
      always_comb begin
         rem_t = {prv.rem[pnfp_pkg::REM_W-3:0], prv.s[pnfp_pkg::SUM_W-1 -: 2]};
         trial = pnfp_pkg::REM_W'({prv.root, 2'b01});
         sq_in[k]      = prv;
         sq_in[k].s    = prv.s << 2;
         if (rem_t >= trial) begin
            sq_in[k].rem  = rem_t - trial;
            sq_in[k].root = {prv.root[pnfp_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k].rem  = rem_t;
            sq_in[k].root = {prv.root[pnfp_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // Restoring division, one quotient bit per stage for all three lanes.
   for (genvar k = 0; k < pnfp_pkg::DV_STAGES; k++) begin : g_dv
      pnfp_pkg::div_type prv;
      logic [pnfp_pkg::DIVR_W-1:0] rt;
      if (k == 0) begin : g_first
         always_comb begin
            prv.len = sq_ff[pnfp_pkg::SQ_STAGES-1].root;
            prv.neg = sq_ff[pnfp_pkg::SQ_STAGES-1].neg;
            prv.q   = '0;
            for (int j = 0; j < 3; j++) begin
               prv.r[j] = pnfp_pkg::DIVR_W'(sq_ff[pnfp_pkg::SQ_STAGES-1].mag[j]);
            end
         end
      end else begin : g_next
         assign prv = dv_ff[k-1];
      end
      always_comb begin
         dv_in[k] = prv;
         for (int j = 0; j < 3; j++) begin
            rt = (k == 0) ? prv.r[j] : (prv.r[j] << 1);
            if (rt >= pnfp_pkg::DIVR_W'(prv.len)) begin
               dv_in[k].r[j] = rt - pnfp_pkg::DIVR_W'(prv.len);
               dv_in[k].q[j] = {prv.q[j][pnfp_pkg::OUT_W-2:0], 1'b1};
            end else begin
               dv_in[k].r[j] = rt;
               dv_in[k].q[j] = {prv.q[j][pnfp_pkg::OUT_W-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // A full-scale positive quotient saturates; the negative one fits as is.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (dv_ff[pnfp_pkg::DV_STAGES-1].len == '0) begin
            norm_in[j] = '0;
         end else if (dv_ff[pnfp_pkg::DV_STAGES-1].neg[j]) begin
            norm_in[j] = -dv_ff[pnfp_pkg::DV_STAGES-1].q[j];
         end else if (dv_ff[pnfp_pkg::DV_STAGES-1].q[j][pnfp_pkg::OUT_W-1]) begin
            norm_in[j] = {1'b0, {(pnfp_pkg::OUT_W-1){1'b1}}};
         end else begin
            norm_in[j] = dv_ff[pnfp_pkg::DV_STAGES-1].q[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff  <= norm_in;
         degen_ff <= (dv_ff[pnfp_pkg::DV_STAGES-1].len == '0);
      end
   end

endmodule
